### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SBI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SBI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// Beat types, register indexes and fixed constants of the burst index unit.
// ----------------------------------------------------------------------------
package sbi_pkg;

  localparam int STAMP_BITS      = 32;
  localparam int OUT_COUNT_BITS  = 24;
  localparam int INDEX_BITS      = 17;
  localparam int FRAC_BITS       = 16;
  localparam int GAP_BITS        = 16;
  localparam int MIN_RUN_BITS    = 8;
  localparam int CFG_INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS   = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = '1;
  localparam logic [GAP_BITS-1:0]       GAP_RESET     = 16'd10;
  localparam logic [MIN_RUN_BITS-1:0]   MIN_RUN_RESET = 8'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RUN       = 8'd1;

  typedef struct packed {
    logic [STAMP_BITS-1:0] stamp_ms;
    logic                  has_spike;
    logic                  neuron_end;
    logic                  window_end;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] burst_cnt;
    logic [OUT_COUNT_BITS-1:0] total_cnt;
    logic [INDEX_BITS-1:0]     ratio_q16;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_DONE
  } back_state_t;

endpackage

### sv/spike_burst_index_unit.sv
// A window result beat passes the queue, then the back part's load, divide and
// done states. One input beat per cycle while the queue is not full; the back
// part takes a new window only once its 16-step restoring divider result is handed off.
// Two closed windows queue between front and back; when full, in_ready drops.
// Reset (rst_n low, synchronous) clears counters, queue and output valid and
// restores gap_threshold_ms to 10 and min_run_spikes to 3.
// ----------------------------------------------------------------------------
// spike_burst_index_unit
// Burst index over analysis windows of spike timestamps: front run tracker,
// queue of closed windows, back ratio divider.
// ----------------------------------------------------------------------------
module spike_burst_index_unit #(
  parameter int COUNT_BITS = 24,
  parameter int TIME_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sbi_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sbi_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sbi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import sbi_pkg::*;

  logic                    q_full;
  logic                    q_push;
  logic [2*COUNT_BITS-1:0] q_wdata;
  logic                    q_pop;
  logic                    q_valid;
  logic [2*COUNT_BITS-1:0] q_rdata;

  sbi_front #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sbi_queue #(
    .DATA_BITS (2*COUNT_BITS)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  sbi_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sv/sbi_front.sv
// ----------------------------------------------------------------------------
// sbi_front
// Accepts spike beats, tracks runs per neuron and window counts, and pushes
// the window's burst and total counts into the queue at each window end.
// ----------------------------------------------------------------------------
module sbi_front #(
  parameter int COUNT_BITS = 24,
  parameter int TIME_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sbi_pkg::in_item_t                   in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sbi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [2*COUNT_BITS-1:0]             q_wdata
);
  import sbi_pkg::*;

  localparam logic [COUNT_BITS-1:0]   COUNT_MAX = '1;
  localparam logic [COUNT_BITS+1:0]   COUNT_MAX_WIDE = {2'b00, COUNT_MAX};

  logic [GAP_BITS-1:0]     gap_thr_r;
  logic [MIN_RUN_BITS-1:0] min_run_r;
  logic [TIME_BITS-1:0]    prev_r,  prev_nxt;
  logic                    have_r,  have_nxt;
  logic                    multi_r, multi_nxt;
  logic [COUNT_BITS-1:0]   run_r,   run_nxt;
  logic [COUNT_BITS-1:0]   wt_r,    wt_nxt;
  logic [COUNT_BITS-1:0]   wb_r,    wb_nxt;

  logic                    accept;
  logic                    closing;
  logic [TIME_BITS-1:0]    t_cur;
  logic [TIME_BITS-1:0]    gap;
  logic                    gap_below;
  logic                    follow;
  logic [COUNT_BITS-1:0]   run_inc;
  logic [COUNT_BITS-1:0]   run_new;
  logic                    multi_new;
  logic [COUNT_BITS-1:0]   wt_new;
  logic                    close_old;
  logic                    close_new;
  logic [COUNT_BITS+1:0]   burst_term;
  logic [COUNT_BITS+1:0]   burst_sum;
  logic [COUNT_BITS-1:0]   wb_new;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign closing   = in_data.neuron_end || in_data.window_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_thr_r <= GAP_RESET;
      min_run_r <= MIN_RUN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GAP_THRESHOLD) begin
        gap_thr_r <= cfg_data;
      end else if (cfg_index == REG_MIN_RUN) begin
        min_run_r <= cfg_data[MIN_RUN_BITS-1:0];
      end
    end
  end

  // Gap to the previous spike, modulo the time width
  assign t_cur     = TIME_BITS'(in_data.stamp_ms);
  assign gap       = t_cur - prev_r;
  assign gap_below = gap < TIME_BITS'(gap_thr_r);
  assign follow    = in_data.has_spike && have_r;
  assign run_inc   = (run_r == COUNT_MAX) ? run_r : run_r + 1'b1;

  // Run length and multi-spike flag after the spike of this beat
  always_comb begin
    run_new = run_r;
    if (in_data.has_spike) begin
      run_new = (follow && gap_below) ? run_inc : COUNT_BITS'(1);
    end
  end
  assign multi_new = multi_r || follow;
  assign wt_new    = !in_data.has_spike ? wt_r :
                     (wt_r == COUNT_MAX) ? wt_r : wt_r + 1'b1;

  // Gap >= threshold closes the old run; a neuron or window end closes the new one
  assign close_old = follow && !gap_below && (run_r >= COUNT_BITS'(min_run_r));
  assign close_new = closing && multi_new && (run_new >= COUNT_BITS'(min_run_r));

  assign burst_term = (close_old ? {2'b00, run_r}   : '0)
                    + (close_new ? {2'b00, run_new} : '0);
  assign burst_sum  = {2'b00, wb_r} + burst_term;
  assign wb_new     = (burst_sum > COUNT_MAX_WIDE) ? COUNT_MAX : burst_sum[COUNT_BITS-1:0];

  // Next state for an accepted beat
  always_comb begin
    prev_nxt  = prev_r;
    have_nxt  = have_r;
    multi_nxt = multi_r;
    run_nxt   = run_r;
    wt_nxt    = wt_r;
    wb_nxt    = wb_r;
    if (accept) begin
      if (in_data.has_spike) begin
        prev_nxt = t_cur;
        have_nxt = 1'b1;
      end
      multi_nxt = multi_new;
      run_nxt   = run_new;
      wt_nxt    = wt_new;
      wb_nxt    = wb_new;
      if (closing) begin
        prev_nxt  = '0;
        have_nxt  = 1'b0;
        multi_nxt = 1'b0;
        run_nxt   = '0;
      end
      if (in_data.window_end) begin
        wt_nxt = '0;
        wb_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      have_r  <= 1'b0;
      multi_r <= 1'b0;
      run_r   <= '0;
      wt_r    <= '0;
      wb_r    <= '0;
    end else begin
      prev_r  <= prev_nxt;
      have_r  <= have_nxt;
      multi_r <= multi_nxt;
      run_r   <= run_nxt;
      wt_r    <= wt_nxt;
      wb_r    <= wb_nxt;
    end
  end

  // Hand the closed window to the back part
  assign q_push  = accept && in_data.window_end;
  assign q_wdata = {wb_new, wt_new};

endmodule

### sv/sbi_queue.sv
// ----------------------------------------------------------------------------
// sbi_queue
// Short first-in first-out queue of closed window counts.
// ----------------------------------------------------------------------------
module sbi_queue #(
  parameter int DATA_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] wdata,
  output logic                 full,
  input  logic                 pop,
  output logic                 rvalid,
  output logic [DATA_BITS-1:0] rdata
);
  import sbi_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);

  logic [DATA_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  cnt_r,    cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == DEPTH_CNT);
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/sbi_back.sv
// ----------------------------------------------------------------------------
// sbi_back
// Takes closed window counts, forms burst/total in Q1.16 with a restoring
// divider one quotient bit per cycle, and holds the result beat.
// ----------------------------------------------------------------------------
module sbi_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  logic [2*COUNT_BITS-1:0]   q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sbi_pkg::out_item_t        out_data
);
  import sbi_pkg::*;

  localparam int STEP_BITS = $clog2(FRAC_BITS);
  localparam int WIDE_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(FRAC_BITS - 1);
  localparam logic [WIDE_BITS-1:0] OUT_MAX_WIDE = WIDE_BITS'(OUT_COUNT_MAX);

  back_state_t             state_r, state_nxt;
  logic [STEP_BITS-1:0]    step_r,  step_nxt;
  logic [COUNT_BITS-1:0]   rem_r,   rem_nxt;
  logic [COUNT_BITS-1:0]   den_r,   den_nxt;
  logic [COUNT_BITS-1:0]   burst_r, burst_nxt;
  logic                    qtop_r,  qtop_nxt;
  logic [FRAC_BITS-1:0]    frac_r,  frac_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r,  out_data_nxt;

  logic [COUNT_BITS-1:0]   in_burst;
  logic [COUNT_BITS-1:0]   in_total;
  logic [COUNT_BITS-1:0]   num_clamp;
  logic                    full_ratio;
  logic [COUNT_BITS:0]     rem_dbl;
  logic                    rem_ge;
  logic [COUNT_BITS:0]     rem_sub;
  logic                    slot_free;
  logic [WIDE_BITS-1:0]    burst_wide;
  logic [WIDE_BITS-1:0]    total_wide;

  assign in_burst   = q_rdata[2*COUNT_BITS-1:COUNT_BITS];
  assign in_total   = q_rdata[COUNT_BITS-1:0];
  assign num_clamp  = (in_burst > in_total) ? in_total : in_burst;
  assign full_ratio = (in_total != '0) && (num_clamp == in_total);

  // One restoring step: shift, compare, subtract
  assign rem_dbl = {rem_r, 1'b0};
  assign rem_ge  = (den_r != '0) && (rem_dbl >= {1'b0, den_r});
  assign rem_sub = rem_dbl - {1'b0, den_r};

  assign slot_free  = !out_valid_r || out_ready;
  assign burst_wide = WIDE_BITS'(burst_r);
  assign total_wide = WIDE_BITS'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    burst_r    <= burst_nxt;
    qtop_r     <= qtop_nxt;
    frac_r     <= frac_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequence load, divide and result hand-off
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    burst_nxt     = burst_r;
    qtop_nxt      = qtop_r;
    frac_nxt      = frac_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          den_nxt   = in_total;
          burst_nxt = in_burst;
          qtop_nxt  = full_ratio;
          rem_nxt   = full_ratio ? '0 : num_clamp;
          frac_nxt  = '0;
          step_nxt  = '0;
          state_nxt = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        rem_nxt  = rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_dbl[COUNT_BITS-1:0];
        frac_nxt = {frac_r[FRAC_BITS-2:0], rem_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.burst_cnt = (burst_wide > OUT_MAX_WIDE) ? OUT_COUNT_MAX
                                   : burst_wide[OUT_COUNT_BITS-1:0];
          out_data_nxt.total_cnt = (total_wide > OUT_MAX_WIDE) ? OUT_COUNT_MAX
                                   : total_wide[OUT_COUNT_BITS-1:0];
          out_data_nxt.ratio_q16 = {qtop_r, frac_r};
          state_nxt              = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/sbi_checker.sv
// ----------------------------------------------------------------------------
// sbi_checker
// Port-level checks on the result channel of the burst index unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sbi_pkg::out_item_t out_data
);
  import sbi_pkg::*;

  // Hold a stalled result beat
  `SBI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SBI_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

  // Ratio never exceeds one in Q1.16
  `SBI_ASSERT_IMP(a_index_range, clk, rst_n, out_valid, out_data.ratio_q16 <= 17'd65536)

  // An empty window reports all zeros
  `SBI_ASSERT_IMP(a_empty_window, clk, rst_n, out_valid && (out_data.total_cnt == '0), (out_data.ratio_q16 == '0) && (out_data.burst_cnt == '0))

endmodule

bind spike_burst_index_unit sbi_checker u_sbi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### dv/spike_burst_index_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spike_burst_index_unit_tb
// Streams spike timestamp beats grouped by neuron and window into the burst
// index unit, predicts each window's burst count, total count and Q1.16
// ratio, and compares every result beat in order. Random idle gaps on both
// channels, a long result hold-off and register changes between phases.
// ----------------------------------------------------------------------------
module spike_burst_index_unit_tb;
  import sbi_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_BEATS     = 90;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int LONG_RUN_SPIKES = 256;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 8'd2;

  // Tracks runs and window counters, queues the expected window results
  class burst_window_tracker;
    logic [GAP_BITS-1:0]       gap_limit;
    logic [MIN_RUN_BITS-1:0]   min_run;
    logic [STAMP_BITS-1:0]     last_time;
    bit                        have_last;
    bit                        multi_spike;
    logic [OUT_COUNT_BITS-1:0] run_len;
    logic [OUT_COUNT_BITS-1:0] win_total;
    logic [OUT_COUNT_BITS-1:0] win_burst;
    out_item_t                 expected_windows[$];
    int unsigned               mismatches;

    function new();
      gap_limit   = GAP_RESET;
      min_run     = MIN_RUN_RESET;
      last_time   = '0;
      have_last   = 1'b0;
      multi_spike = 1'b0;
      run_len     = '0;
      win_total   = '0;
      win_burst   = '0;
      mismatches  = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_GAP_THRESHOLD) begin
        gap_limit = data;
      end else if (idx == REG_MIN_RUN) begin
        min_run = data[MIN_RUN_BITS-1:0];
      end
    endfunction

    function logic [OUT_COUNT_BITS-1:0] sat_add(logic [OUT_COUNT_BITS-1:0] a,
                                                logic [OUT_COUNT_BITS-1:0] b);
      logic [OUT_COUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[OUT_COUNT_BITS] ? OUT_COUNT_MAX : sum[OUT_COUNT_BITS-1:0];
    endfunction

    // A run of a multi-spike neuron counts once it reaches the minimum
    function void close_run();
      if (multi_spike && run_len >= min_run) begin
        win_burst = sat_add(win_burst, run_len);
      end
    endfunction

    function void absorb_spike_beat(in_item_t beat);
      logic [STAMP_BITS-1:0]      gap;
      logic [OUT_COUNT_BITS-1:0]  capped;
      logic [39:0]                numer;
      logic [39:0]                quot;
      out_item_t                  res;
      if (beat.has_spike) begin
        win_total = sat_add(win_total, OUT_COUNT_BITS'(1));
        if (have_last) begin
          gap = beat.stamp_ms - last_time;
          multi_spike = 1'b1;
          if (gap < {16'h0000, gap_limit}) begin
            run_len = sat_add(run_len, OUT_COUNT_BITS'(1));
          end else begin
            close_run();
            run_len = OUT_COUNT_BITS'(1);
          end
        end else begin
          run_len = OUT_COUNT_BITS'(1);
        end
        last_time = beat.stamp_ms;
        have_last = 1'b1;
      end
      // Window end closes the open neuron too
      if (beat.neuron_end || beat.window_end) begin
        close_run();
        last_time   = '0;
        have_last   = 1'b0;
        multi_spike = 1'b0;
        run_len     = '0;
      end
      if (beat.window_end) begin
        quot = '0;
        if (win_total != 0) begin
          capped = (win_burst > win_total) ? win_total : win_burst;
          numer  = {capped, 16'h0000};
          quot   = numer / {16'h0000, win_total};
          if (quot > 40'd65536) begin
            quot = 40'd65536;
          end
        end
        res.burst_cnt = win_burst;
        res.total_cnt = win_total;
        res.ratio_q16 = quot[INDEX_BITS-1:0];
        expected_windows.push_back(res);
        win_total = '0;
        win_burst = '0;
      end
    endfunction

    function void check_window_result(out_item_t got);
      out_item_t exp_res;
      if (expected_windows.size() == 0) begin
        $display("%0t: window result with nothing pending: burst=%0d total=%0d index=%0d",
                 $time, got.burst_cnt, got.total_cnt, got.ratio_q16);
        mismatches++;
        return;
      end
      exp_res = expected_windows.pop_front();
      if (got.burst_cnt !== exp_res.burst_cnt) begin
        $display("%0t: burst count expected %0d, got %0d",
                 $time, exp_res.burst_cnt, got.burst_cnt);
        mismatches++;
      end
      if (got.total_cnt !== exp_res.total_cnt) begin
        $display("%0t: total count expected %0d, got %0d",
                 $time, exp_res.total_cnt, got.total_cnt);
        mismatches++;
      end
      if (got.ratio_q16 !== exp_res.ratio_q16) begin
        $display("%0t: ratio expected %0d, got %0d",
                 $time, exp_res.ratio_q16, got.ratio_q16);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  burst_window_tracker tracker = new();
  int unsigned         beats_sent = 0;
  bit                  tx_steady = 1'b0;
  bit                  rx_steady = 1'b0;
  bit                  hold_request = 1'b0;

  spike_burst_index_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bound the run
  initial begin
    #12_000_000;
    $display("spike_burst_index_unit_tb NOT OK");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Timestamp step: mostly inside the gap limit, else at, above or backward
  function automatic logic [STAMP_BITS-1:0] pick_step(logic [GAP_BITS-1:0] thr,
                                                      bit keep_run);
    logic [STAMP_BITS-1:0] below;
    below = (thr == 0) ? 32'd0 : 32'($urandom_range(0, thr - 1));
    if (keep_run) return below;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return below;
      6:                return {16'h0000, thr};
      7:                return {16'h0000, thr} + 32'd1;
      8:                return $urandom;
      default:          return -32'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic in_item_t make_beat(logic [STAMP_BITS-1:0] t, logic s,
                                         logic ne, logic we);
    in_item_t b;
    b.stamp_ms   = t;
    b.has_spike  = s;
    b.neuron_end = ne;
    b.window_end = we;
    return b;
  endfunction

  // Offer one beat, hold it until accepted
  task automatic send_beat(in_item_t beat);
    int unsigned idle;
    idle = tx_steady ? 0 : pick_idle();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    tracker.absorb_spike_beat(beat);
    beats_sent++;
  endtask

  // One window of neurons with random spike trains and closing styles
  task automatic send_window(int max_neurons, int long_spikes);
    in_item_t              beats[$];
    in_item_t              tail;
    int                    n_neurons;
    int                    n_spikes;
    int unsigned           r;
    bit                    long_neuron;
    logic [STAMP_BITS-1:0] spike_t;
    n_neurons = $urandom_range(long_spikes > 0 ? 1 : 0, max_neurons);
    for (int nr = 0; nr < n_neurons; nr++) begin
      long_neuron = (nr == 0) && (long_spikes > 0);
      r = $urandom_range(0, 9);
      if (long_neuron) n_spikes = long_spikes;
      else if (r == 0) n_spikes = 0;
      else if (r == 1) n_spikes = 1;
      else n_spikes = $urandom_range(2, 8);
      spike_t = $urandom;
      for (int s = 0; s < n_spikes; s++) begin
        // idle beat with no spike and no marker
        if ($urandom_range(0, 19) == 0) beats.push_back(make_beat($urandom, 0, 0, 0));
        if (s != 0) spike_t += pick_step(tracker.gap_limit, long_neuron);
        beats.push_back(make_beat(spike_t, 1, 0, 0));
      end
      // close on the last spike or by a marker; rarely drop the close
      r = $urandom_range(0, 19);
      if (r != 0) begin
        if (n_spikes == 0 || r < 8) begin
          beats.push_back(make_beat($urandom, 0, 1, 0));
        end else begin
          tail = beats.pop_back();
          tail.neuron_end = 1'b1;
          beats.push_back(tail);
        end
      end
    end
    // close the window by a marker or on the last beat, with or without neuron end
    r = $urandom_range(0, 3);
    if (beats.size() == 0 || r == 0) begin
      beats.push_back(make_beat($urandom, 0, 1'($urandom_range(0, 1)), 1));
    end else begin
      tail = beats.pop_back();
      tail.window_end = 1'b1;
      if (r == 1) tail.neuron_end = 1'b0;
      beats.push_back(tail);
    end
    foreach (beats[i]) send_beat(beats[i]);
  endtask

  // Wait for every window result, then let the pipeline settle
  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int max_neurons, int long_spikes);
    int unsigned start;
    start = beats_sent;
    if (long_spikes > 0) send_window(max_neurons, long_spikes);
    while (beats_sent - start < PHASE_BEATS) send_window(max_neurons, 0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Keep cfg_valid high across back-to-back writes
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
  endtask

  task automatic configure(logic [GAP_BITS-1:0] gap, logic [MIN_RUN_BITS-1:0] min_len,
                           bit poke_unmapped);
    write_reg(REG_GAP_THRESHOLD, gap);
    write_reg(REG_MIN_RUN, {8'($urandom), min_len});
    if (poke_unmapped) write_reg(REG_UNMAPPED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_window_result(out_data);
    end
  end

  // Result side: random stalls, steady stretches and one long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        out_ready   <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_steady || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_idle();
        out_ready <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    in_item_t directed[$];
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed windows at reset settings: empty window, single spike at the
    // top timestamp, run ended by a gap equal to the limit, wrapping run,
    // backward step, window end without neuron end, all flags on one beat
    directed.push_back(make_beat(32'h0000_0000, 0, 0, 1));
    directed.push_back(make_beat(32'hFFFF_FFFF, 1, 1, 0));
    directed.push_back(make_beat(32'hAAAA_AAAA, 0, 0, 1));
    directed.push_back(make_beat(32'd100, 1, 0, 0));
    directed.push_back(make_beat(32'd105, 1, 0, 0));
    directed.push_back(make_beat(32'd114, 1, 0, 0));
    directed.push_back(make_beat(32'd124, 1, 0, 0));
    directed.push_back(make_beat(32'd133, 1, 1, 0));
    directed.push_back(make_beat(32'h5555_5555, 0, 0, 0));
    directed.push_back(make_beat(32'hFFFF_FFFC, 1, 0, 0));
    directed.push_back(make_beat(32'h0000_0002, 1, 0, 0));
    directed.push_back(make_beat(32'h0000_0004, 1, 0, 0));
    directed.push_back(make_beat(32'h0000_0000, 0, 1, 0));
    directed.push_back(make_beat(32'd500, 1, 0, 0));
    directed.push_back(make_beat(32'd400, 1, 0, 0));
    directed.push_back(make_beat(32'd401, 1, 0, 1));
    directed.push_back(make_beat(32'h7FFF_FFFF, 1, 1, 1));
    foreach (directed[i]) send_beat(directed[i]);
    in_valid <= 1'b0;
    wait_drained();

    // Zero limit and zero minimum: every run is one spike, and each run of a multi-spike neuron counts
    configure('0, '0, 1'b0);
    run_phase(4, 0);

    // Widest limit and largest minimum, with one long run
    configure('1, '1, 1'b0);
    run_phase(3, LONG_RUN_SPIKES);

    // No idling on either side
    configure(16'd1, 8'd1, 1'b0);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_phase(4, 0);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    configure(16'($urandom_range(2, 200)), 8'($urandom_range(2, 6)), 1'b1);
    run_phase(4, 0);

    // Hold off results while short windows keep coming, so the unit backs up
    configure(16'd20, 8'd2, 1'b0);
    tx_steady    = 1'b1;
    hold_request = 1'b1;
    run_phase(1, 0);
    tx_steady = 1'b0;

    configure(16'($urandom), 8'($urandom), 1'b0);
    run_phase(4, 0);

    configure(GAP_RESET, MIN_RUN_RESET, 1'b0);
    run_phase(4, 0);

    if (tracker.mismatches == 0) begin
      $display("spike_burst_index_unit_tb OK");
    end else begin
      $display("spike_burst_index_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sbi_pkg.sv
sv/sbi_front.sv
sv/sbi_queue.sv
sv/sbi_back.sv
sv/spike_burst_index_unit.sv
sv/sbi_checker.sv
dv/spike_burst_index_unit_tb.sv
